// ----- hw/rtl/bgc_pkg.sv -----
// bgc_pkg: shared types, constants and helpers for the button gesture classifier.
// No dependencies; imported by every module of the block.
package bgc_pkg;

	localparam int MAX_BUTTONS = 8;
	localparam int TIME_BITS   = 32;
	localparam int IDX_W       = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam int CNT_W       = $clog2(MAX_BUTTONS + 1);
	localparam int ADDR_W      = 5;

	typedef logic [TIME_BITS-1:0] tstamp_t;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_DOUBLE  = 3'd2,
		EV_LONG    = 3'd3,
		EV_REPEAT  = 3'd4,
		EV_CLICK   = 3'd5
	} evt_kind_t;

	typedef enum logic [2:0] {
		REG_BUTTON_COUNT = 3'd0,
		REG_DEBOUNCE     = 3'd1,
		REG_LONG_PRESS   = 3'd2,
		REG_REPEAT       = 3'd3,
		REG_CLICK_WINDOW = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_PUSH,
		ST_FLUSH
	} seq_state_t;

	// per-button state word held in the state RAM
	typedef struct packed {
		tstamp_t    edge_time;
		tstamp_t    press_start;
		tstamp_t    repeat_stamp;
		tstamp_t    click_stamp;
		logic [1:0] click_tally;
	} btn_state_t;

	typedef struct packed {
		logic [15:0] debounce_time;
		logic [15:0] long_press_time;
		logic [15:0] repeat_time;
		logic [15:0] click_window;
	} timing_cfg_t;

	// up to two events per button per transaction
	typedef struct packed {
		logic [1:0] count;
		evt_kind_t  kind0;
		evt_kind_t  kind1;
	} ev_set_t;

	// sequencer -> event stage
	typedef struct packed {
		logic             valid;
		logic             flush;
		evt_kind_t        kind;
		logic [IDX_W-1:0] idx;
	} ev_push_t;

	function automatic tstamp_t elapsed(input tstamp_t now, input tstamp_t then);
		elapsed = now - then;
	endfunction

endpackage

// ----- hw/rtl/bgc_state_ram.sv -----
// bgc_state_ram: per-button state memory, one write and one registered read port.
// Valid bits make unwritten entries read as zero after reset. Uses bgc_pkg.
module bgc_state_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [bgc_pkg::IDX_W-1:0] waddr,
	input  bgc_pkg::btn_state_t       wdata,
	input  logic [bgc_pkg::IDX_W-1:0] raddr,
	output bgc_pkg::btn_state_t       rdata
);
	import bgc_pkg::*;

	btn_state_t             mem [MAX_BUTTONS];
	logic [MAX_BUTTONS-1:0] vld_q;
	btn_state_t             rd_data_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- hw/rtl/bgc_gesture_eval.sv -----
// bgc_gesture_eval: debounce and gesture rules for one button, read-modify-write data path.
// Combinational; uses bgc_pkg.
module bgc_gesture_eval (
	input  logic                 pressed,
	input  logic                 was,
	input  bgc_pkg::tstamp_t     now,
	input  bgc_pkg::timing_cfg_t cfg,
	input  bgc_pkg::btn_state_t  cur,
	output bgc_pkg::btn_state_t  nxt,
	output bgc_pkg::ev_set_t     evs
);
	import bgc_pkg::*;

	always_comb begin
		nxt = cur;
		evs = '{count: 2'd0, kind0: EV_PRESS, kind1: EV_PRESS};
		if (pressed != was && elapsed(now, cur.edge_time) < TIME_BITS'(cfg.debounce_time)) begin
			// bounce: button left untouched this transaction
		end else begin
			if (pressed != was) begin
				nxt.edge_time = now;
				if (pressed) begin
					nxt.press_start  = now;
					nxt.repeat_stamp = '0;
					evs.kind0 = EV_PRESS;
					evs.count = 2'd1;
				end else begin
					evs.kind0 = EV_RELEASE;
					evs.count = 2'd1;
					nxt.repeat_stamp = '0;
					if (elapsed(now, nxt.press_start) < TIME_BITS'(cfg.long_press_time)) begin
						nxt.click_tally = nxt.click_tally + 2'd1;
						if (nxt.click_tally == 2'd1) begin
							nxt.click_stamp = now;
						end else begin
							evs.kind1 = EV_DOUBLE;
							evs.count = 2'd2;
							nxt.click_tally = 2'd0;
						end
					end
				end
			end
			// held past the long-press limit
			if (pressed && elapsed(now, nxt.press_start) > TIME_BITS'(cfg.long_press_time)) begin
				if (nxt.repeat_stamp == '0) begin
					if (evs.count == 2'd0) evs.kind0 = EV_LONG;
					else                   evs.kind1 = EV_LONG;
					evs.count = evs.count + 2'd1;
					nxt.repeat_stamp = now;
				end
				if (elapsed(now, nxt.repeat_stamp) > TIME_BITS'(cfg.repeat_time)) begin
					if (evs.count == 2'd0) evs.kind0 = EV_REPEAT;
					else                   evs.kind1 = EV_REPEAT;
					evs.count = evs.count + 2'd1;
					nxt.repeat_stamp = now;
				end
			end
			// lone click whose window ran out
			if (nxt.click_tally == 2'd1 &&
			    elapsed(now, nxt.click_stamp) > TIME_BITS'(cfg.click_window)) begin
				if (evs.count == 2'd0) evs.kind0 = EV_CLICK;
				else                   evs.kind1 = EV_CLICK;
				evs.count = evs.count + 2'd1;
				nxt.click_tally = 2'd0;
			end
		end
	end

endmodule

// ----- hw/rtl/bgc_event_out.sv -----
// bgc_event_out: one-event holdback plus output register; marks the final event of a transaction.
// Uses bgc_pkg.
module bgc_event_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bgc_pkg::ev_push_t          push,
	output logic                       push_ready,
	output logic                       event_valid,
	input  logic                       event_stall,
	output logic [2:0]                 event_kind,
	output logic [2:0]                 button_index,
	output logic                       last_event
);
	import bgc_pkg::*;

	logic             hb_v_q;
	evt_kind_t        hb_kind_q;
	logic [IDX_W-1:0] hb_idx_q;
	logic             out_v_q;
	evt_kind_t        out_kind_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_last_q;
	logic             out_free;
	logic             take;

	assign out_free   = !out_v_q || !event_stall;
	assign push_ready = !hb_v_q || out_free;
	assign take       = push.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take && hb_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !event_stall) begin
				out_v_q <= 1'b0;
			end
			if (take) begin
				hb_v_q <= !push.flush;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && hb_v_q) begin
			out_kind_q <= hb_kind_q;
			out_idx_q  <= hb_idx_q;
			out_last_q <= push.flush;
		end
		if (take && !push.flush) begin
			hb_kind_q <= push.kind;
			hb_idx_q  <= push.idx;
		end
	end

	assign event_valid  = out_v_q;
	assign event_kind   = out_kind_q;
	assign button_index = 3'(out_idx_q);
	assign last_event   = out_last_q;

endmodule

// ----- hw/rtl/button_gesture_classifier_top.sv -----
// button_gesture_classifier_top: APB registers, per-button sequencer and top-level wiring.
// Depends on bgc_pkg, bgc_state_ram, bgc_gesture_eval, bgc_event_out.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------------------
//  item      | in        | item_valid / item_stall    | time_ms, pressed_bits
//  event     | out       | event_valid / event_stall  | event_kind, button_index, last_event
//  apb       | in/out    | psel, penable, pready      | paddr, pwrite, pwdata, prdata
//
// One transaction at a time. After acceptance the sequencer reads button 0 from the state
// RAM through its registered read port, then evaluates one button per cycle while no events
// are pending, writing the updated word back in the same cycle. Each event passes through the
// push state and a fresh RAM read for the next button. Reset clears the config registers to
// their defaults, the previous mask and the RAM valid bits; no clearing pass is needed.
// Stalls on the event channel hold the sequencer in its push or flush state; item_stall
// stays high until the last event of the transaction is staged.
module button_gesture_classifier_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// item channel
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [31:0]                time_ms,
	input  logic [7:0]                 pressed_bits,
	// event channel
	output logic                       event_valid,
	input  logic                       event_stall,
	output logic [2:0]                 event_kind,
	output logic [2:0]                 button_index,
	output logic                       last_event,
	// config port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bgc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import bgc_pkg::*;

	// config registers
	logic [3:0]  button_count_q;
	timing_cfg_t cfg_q;
	logic        cfg_wr;
	reg_idx_t    reg_sel;

	// sequencer
	seq_state_t       state_q, state_nxt;
	logic [IDX_W-1:0] btn_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_eff;
	tstamp_t          now_q;
	logic [7:0]       mask_q;
	logic [7:0]       was_q;
	logic [7:0]       prev_mask_q;
	ev_set_t          evs_q;
	logic             sel_q;

	logic             item_take;
	logic             last_btn;
	logic             mem_we;
	logic [IDX_W-1:0] rd_addr;
	btn_state_t       rd_word;
	btn_state_t       wr_word;
	ev_set_t          evs;
	ev_push_t         push;
	logic             push_ready;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_count_q        <= 4'd8;
			cfg_q.debounce_time   <= 16'd50;
			cfg_q.long_press_time <= 16'd800;
			cfg_q.repeat_time     <= 16'd200;
			cfg_q.click_window    <= 16'd300;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_BUTTON_COUNT: button_count_q        <= pwdata[3:0];
				REG_DEBOUNCE:     cfg_q.debounce_time   <= pwdata[15:0];
				REG_LONG_PRESS:   cfg_q.long_press_time <= pwdata[15:0];
				REG_REPEAT:       cfg_q.repeat_time     <= pwdata[15:0];
				REG_CLICK_WINDOW: cfg_q.click_window    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BUTTON_COUNT: prdata = {28'd0, button_count_q};
			REG_DEBOUNCE:     prdata = {16'd0, cfg_q.debounce_time};
			REG_LONG_PRESS:   prdata = {16'd0, cfg_q.long_press_time};
			REG_REPEAT:       prdata = {16'd0, cfg_q.repeat_time};
			REG_CLICK_WINDOW: prdata = {16'd0, cfg_q.click_window};
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	// counts above the number of buttons saturate
	assign cnt_eff = (button_count_q > 4'(MAX_BUTTONS)) ? CNT_W'(MAX_BUTTONS)
	                                                    : CNT_W'(button_count_q);
	assign item_stall = (state_q != ST_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign last_btn   = (CNT_W'(btn_q) + CNT_W'(1)) == cnt_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_take && cnt_eff != '0) state_nxt = ST_READ;
			end
			ST_READ: state_nxt = ST_EVAL;
			ST_EVAL: begin
				if (evs.count != 2'd0) state_nxt = ST_PUSH;
				else if (last_btn)     state_nxt = ST_FLUSH;
			end
			ST_PUSH: begin
				if (push_ready && (sel_q || evs_q.count == 2'd1)) begin
					state_nxt = last_btn ? ST_FLUSH : ST_READ;
				end
			end
			ST_FLUSH: begin
				if (push_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		rd_addr    = btn_q;
		push.valid = 1'b0;
		push.flush = 1'b0;
		push.kind  = sel_q ? evs_q.kind1 : evs_q.kind0;
		push.idx   = btn_q;
		unique case (state_q)
			ST_IDLE:  ;
			ST_READ:  ;
			ST_EVAL: begin
				mem_we  = 1'b1;
				// prefetch the next button while this one is written back
				rd_addr = btn_q + IDX_W'(1);
			end
			ST_PUSH:  push.valid = 1'b1;
			ST_FLUSH: begin
				push.valid = 1'b1;
				push.flush = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_mask_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (item_take) begin
				// the mask always moves on, even when every edge bounces
				prev_mask_q <= pressed_bits;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			now_q  <= time_ms[TIME_BITS-1:0];
			mask_q <= pressed_bits;
			was_q  <= prev_mask_q;
			cnt_q  <= cnt_eff;
			btn_q  <= '0;
		end
		if (state_q == ST_EVAL) begin
			evs_q <= evs;
			sel_q <= 1'b0;
			if (evs.count == 2'd0 && !last_btn) btn_q <= btn_q + IDX_W'(1);
		end
		if (state_q == ST_PUSH && push_ready) begin
			if (sel_q || evs_q.count == 2'd1) begin
				if (!last_btn) btn_q <= btn_q + IDX_W'(1);
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- datapath
	bgc_state_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (btn_q),
		.wdata  (wr_word),
		.raddr  (rd_addr),
		.rdata  (rd_word)
	);

	bgc_gesture_eval u_eval (
		.pressed (mask_q[btn_q]),
		.was     (was_q[btn_q]),
		.now     (now_q),
		.cfg     (cfg_q),
		.cur     (rd_word),
		.nxt     (wr_word),
		.evs     (evs)
	);

	bgc_event_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_ready   (push_ready),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_kind   (event_kind),
		.button_index (button_index),
		.last_event   (last_event)
	);

endmodule
